### hw/rtl/rtp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtp_pkg;

	// Fraction digits accepted after the dot; a digit past the sixth makes the string bad
	localparam int FRAC_DIGITS = 6;
	localparam int FRAC_CNT_W  = $clog2(FRAC_DIGITS + 1);
	localparam int MICRO_DIGITS = 6;

	// Length of the fixed "YYYY-MM-DDTHH:MM:SS" part and of "HH:MM" after a sign
	localparam int FIXED_LEN = 19;
	localparam int ZONE_LEN  = 5;
	localparam int POS_W     = 5;

	// Character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_T_UP  = 8'h54;
	localparam logic [7:0] CH_T_LO  = 8'h74;
	localparam logic [7:0] CH_Z_UP  = 8'h5A;
	localparam logic [7:0] CH_Z_LO  = 8'h7A;

	localparam logic [13:0] YEAR_MAX = 14'd9999;

	// Weight of each fraction digit in microseconds
	localparam logic [19:0] MICRO_WEIGHT [MICRO_DIGITS] = '{
		20'd100000, 20'd10000, 20'd1000, 20'd100, 20'd10, 20'd1
	};

	// Parse phase, one-hot
	typedef enum logic [4:0] {
		PH_FIXED  = 5'b00001,
		PH_SECS   = 5'b00010,
		PH_FRAC   = 5'b00100,
		PH_ZULU   = 5'b01000,
		PH_OFFSET = 5'b10000
	} phase_t;

	// Expected character class in the fixed part
	typedef enum logic [2:0] {
		SH_DIGIT,
		SH_DASH,
		SH_TEE,
		SH_COLON,
		SH_NONE
	} shape_t;

	typedef struct packed {
		phase_t                  phase;
		logic [POS_W-1:0]        pos;
		logic                    err;
		logic [13:0]             year;
		logic [6:0]              year_hi;
		logic                    year_lo_zero;
		logic [6:0]              month;
		logic [6:0]              day;
		logic [6:0]              hour;
		logic [6:0]              minute;
		logic [6:0]              second;
		logic [19:0]             frac;
		logic [FRAC_CNT_W-1:0]   frac_digits;
		logic                    zone_neg;
		logic [6:0]              zone_hour;
		logic [6:0]              zone_minute;
	} scan_state_t;

	// Scan state at the start of a string: date phase, everything else clear
	localparam scan_state_t SCAN_INIT =
		{PH_FIXED, {($bits(scan_state_t) - $bits(phase_t)){1'b0}}};

	typedef struct packed {
		logic               parse_ok;
		logic [13:0]        year_value;
		logic [3:0]         month_value;
		logic [4:0]         day_value;
		logic [4:0]         hour_value;
		logic [5:0]         minute_value;
		logic [5:0]         second_value;
		logic [19:0]        micro_seconds;
		logic signed [11:0] zone_offset_minutes;
	} stamp_t;

	// Shape of "YYYY-MM-DDTHH:MM:SS" by position
	function automatic shape_t shape_at(input logic [POS_W-1:0] pos);
		shape_t s;
		unique case (pos)
			5'd4, 5'd7:   s = SH_DASH;
			5'd10:        s = SH_TEE;
			5'd13, 5'd16: s = SH_COLON;
			5'd0, 5'd1, 5'd2, 5'd3, 5'd5, 5'd6, 5'd8, 5'd9, 5'd11, 5'd12,
			5'd14, 5'd15, 5'd17, 5'd18: s = SH_DIGIT;
			default:      s = SH_NONE;
		endcase
		return s;
	endfunction

	// Days in a month; codes outside 1..12 never reach a valid result
	function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		unique case (m)
			4'd2:                      d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
			default:                   d = 5'd31;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/rtp_char_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rtp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       is_last;

	modport source (output valid, output char_code, output is_last, input ready);
	modport sink (input valid, input char_code, input is_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/rtp_stamp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rtp_stamp_if;
	logic               valid;
	logic               ready;
	logic               parse_ok;
	logic [13:0]        year_value;
	logic [3:0]         month_value;
	logic [4:0]         day_value;
	logic [4:0]         hour_value;
	logic [5:0]         minute_value;
	logic [5:0]         second_value;
	logic [19:0]        micro_seconds;
	logic signed [11:0] zone_offset_minutes;

	modport source (
		output valid, output parse_ok, output year_value, output month_value,
		output day_value, output hour_value, output minute_value, output second_value,
		output micro_seconds, output zone_offset_minutes, input ready
	);
	modport sink (
		input valid, input parse_ok, input year_value, input month_value,
		input day_value, input hour_value, input minute_value, input second_value,
		input micro_seconds, input zone_offset_minutes, output ready
	);
endinterface

`default_nettype wire

### hw/rtl/rtp_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module rtp_scan (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic [7:0]          ch,
	input  wire logic                last,
	output rtp_pkg::scan_state_t     nx
);

	rtp_pkg::scan_state_t st_q;
	logic                 is_dig;
	logic [3:0]           dv;
	logic [19:0]          wt;
	rtp_pkg::shape_t      shp;

	assign is_dig = (ch >= rtp_pkg::CH_ZERO) && (ch <= rtp_pkg::CH_NINE);
	assign dv     = ch[3:0];
	assign shp    = rtp_pkg::shape_at(st_q.pos);

	// Pick the microsecond weight of the next fraction digit
	always_comb begin
		wt = '0;
		for (int k = 0; k < rtp_pkg::MICRO_DIGITS; k++) begin
			if (int'(st_q.frac_digits) == k) begin
				wt = rtp_pkg::MICRO_WEIGHT[k];
			end
		end
	end

	// Start of the zone: Z, or a sign that opens an offset
	function automatic rtp_pkg::scan_state_t zone_start(
		input rtp_pkg::scan_state_t s,
		input logic [7:0]           c
	);
		rtp_pkg::scan_state_t r;
		r = s;
		if (c == rtp_pkg::CH_Z_UP || c == rtp_pkg::CH_Z_LO) begin
			r.phase = rtp_pkg::PH_ZULU;
		end else if (c == rtp_pkg::CH_PLUS || c == rtp_pkg::CH_DASH) begin
			r.zone_neg = (c == rtp_pkg::CH_DASH);
			r.phase    = rtp_pkg::PH_OFFSET;
			r.pos      = '0;
		end else begin
			r.err = 1'b1;
		end
		return r;
	endfunction

	// Next state for the character in hand; spaces leave it untouched
	always_comb begin
		nx = st_q;
		if (ch != rtp_pkg::CH_SPACE) begin
			unique case (st_q.phase)
				rtp_pkg::PH_FIXED: begin
					if (shp == rtp_pkg::SH_DIGIT && !is_dig) begin
						nx.err = 1'b1;
					end else begin
						unique case (shp)
							rtp_pkg::SH_DIGIT: begin
								if (st_q.pos < 5'd4) begin
									nx.year = 14'(st_q.year * 14'd10 + 14'(dv));
									if (st_q.pos < 5'd2) begin
										nx.year_hi = 7'(st_q.year_hi * 7'd10 + 7'(dv));
									end else if (st_q.pos == 5'd2) begin
										nx.year_lo_zero = (dv == 4'd0);
									end else begin
										nx.year_lo_zero = st_q.year_lo_zero && (dv == 4'd0);
									end
								end else if (st_q.pos < 5'd7) begin
									nx.month = 7'(st_q.month * 7'd10 + 7'(dv));
								end else if (st_q.pos < 5'd10) begin
									nx.day = 7'(st_q.day * 7'd10 + 7'(dv));
								end else if (st_q.pos < 5'd13) begin
									nx.hour = 7'(st_q.hour * 7'd10 + 7'(dv));
								end else if (st_q.pos < 5'd16) begin
									nx.minute = 7'(st_q.minute * 7'd10 + 7'(dv));
								end else begin
									nx.second = 7'(st_q.second * 7'd10 + 7'(dv));
								end
							end
							rtp_pkg::SH_TEE: begin
								if (ch != rtp_pkg::CH_T_UP && ch != rtp_pkg::CH_T_LO) begin
									nx.err = 1'b1;
								end
							end
							rtp_pkg::SH_DASH: begin
								if (ch != rtp_pkg::CH_DASH) nx.err = 1'b1;
							end
							rtp_pkg::SH_COLON: begin
								if (ch != rtp_pkg::CH_COLON) nx.err = 1'b1;
							end
							default: nx.err = 1'b1;
						endcase
						nx.pos = st_q.pos + 5'd1;
						if (st_q.pos == 5'(rtp_pkg::FIXED_LEN - 1)) begin
							nx.phase = rtp_pkg::PH_SECS;
						end
					end
				end
				rtp_pkg::PH_SECS: begin
					if (ch == rtp_pkg::CH_DOT) begin
						nx.phase       = rtp_pkg::PH_FRAC;
						nx.frac_digits = '0;
					end else begin
						nx = zone_start(st_q, ch);
					end
				end
				rtp_pkg::PH_FRAC: begin
					if (is_dig) begin
						if (st_q.frac_digits >= rtp_pkg::FRAC_CNT_W'(rtp_pkg::FRAC_DIGITS)) begin
							nx.err = 1'b1;
						end else begin
							nx.frac        = 20'(24'(st_q.frac) + 24'(dv) * 24'(wt));
							nx.frac_digits = st_q.frac_digits + rtp_pkg::FRAC_CNT_W'(1);
						end
					end else if (st_q.frac_digits == '0) begin
						nx.err = 1'b1;
					end else begin
						nx = zone_start(st_q, ch);
					end
				end
				rtp_pkg::PH_OFFSET: begin
					if (st_q.pos == 5'd2) begin
						if (ch != rtp_pkg::CH_COLON) nx.err = 1'b1;
					end else if (st_q.pos < 5'(rtp_pkg::ZONE_LEN) && is_dig) begin
						if (st_q.pos < 5'd2) begin
							nx.zone_hour = 7'(st_q.zone_hour * 7'd10 + 7'(dv));
						end else begin
							nx.zone_minute = 7'(st_q.zone_minute * 7'd10 + 7'(dv));
						end
					end else begin
						nx.err = 1'b1;
					end
					if (st_q.pos < 5'(rtp_pkg::ZONE_LEN)) nx.pos = st_q.pos + 5'd1;
				end
				default: nx.err = 1'b1;
			endcase
		end
	end

	// Advance on each item; return to the start after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= rtp_pkg::SCAN_INIT;
		end else if (take) begin
			if (last) begin
				st_q <= rtp_pkg::SCAN_INIT;
			end else begin
				st_q <= nx;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/rtp_check.sv
`timescale 1ns / 1ps
`default_nettype none

module rtp_check (
	input  wire rtp_pkg::scan_state_t st,
	output rtp_pkg::stamp_t           res
);

	logic        leap;
	logic [4:0]  limit;
	logic        date_ok;
	logic        time_ok;
	logic        shape_ok;
	logic        zone_ok;
	logic        ok;
	logic [11:0] off;

	// Leap year: century years go by the first two digits
	assign leap = st.year_lo_zero ? (st.year_hi[1:0] == 2'd0) : (st.year[1:0] == 2'd0);
	assign limit = rtp_pkg::month_length(st.month[3:0], leap);

	assign date_ok = (st.year >= 14'd1) && (st.year <= rtp_pkg::YEAR_MAX)
		&& (st.month >= 7'd1) && (st.month <= 7'd12)
		&& (st.day >= 7'd1) && (st.day <= 7'(limit));
	assign time_ok = (st.hour <= 7'd23) && (st.minute <= 7'd59) && (st.second <= 7'd59);

	// The string must end at a complete point
	assign shape_ok = !st.err && (st.phase != rtp_pkg::PH_FIXED)
		&& !(st.phase == rtp_pkg::PH_FRAC && st.frac_digits == '0)
		&& !(st.phase == rtp_pkg::PH_OFFSET && st.pos != 5'(rtp_pkg::ZONE_LEN));
	assign zone_ok = (st.phase != rtp_pkg::PH_OFFSET)
		|| ((st.zone_hour <= 7'd23) && (st.zone_minute <= 7'd59));
	assign ok = shape_ok && date_ok && time_ok && zone_ok;

	// Offset in minutes: hour * 60 as two shifts
	assign off = (12'(st.zone_hour) << 6) - (12'(st.zone_hour) << 2) + 12'(st.zone_minute);

	// Fill the result, all zero when the string is bad
	always_comb begin
		res = '0;
		if (ok) begin
			res.parse_ok      = 1'b1;
			res.year_value    = st.year;
			res.month_value   = st.month[3:0];
			res.day_value     = st.day[4:0];
			res.hour_value    = st.hour[4:0];
			res.minute_value  = st.minute[5:0];
			res.second_value  = st.second[5:0];
			res.micro_seconds = st.frac;
			if (st.phase == rtp_pkg::PH_OFFSET) begin
				res.zone_offset_minutes = st.zone_neg ? -$signed(off) : $signed(off);
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/rfc3339_timestamp_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// RFC 3339 timestamp parser.
// chars: one character item per cycle unless stalled (char_code, is_last); spaces are skipped.
// stamp: one result item per string, given for the item marked is_last, with
//   parse_ok and the date, time, microsecond and zone offset fields (all zero
//   when parse_ok is low).
// Path: a taken character is registered in the input register, and its result,
//   if it is the last one, is registered in the result register and shown on stamp.
// Throughput: one character per cycle unless a last character is stalled; a new
//   string may start on the cycle after the last character of the previous one.
//   The per-cycle work is one digit accumulate on the scan state plus the range
//   checks, between the input register and the result register.
// Stall: while a result waits on stamp, characters that are not last keep
//   flowing; a further last character waits in the input register until the
//   pending result is taken.
// Reset: clears both valid flags and returns the scan state to the start of a
//   string; the block is ready for characters once reset is released.
module rfc3339_timestamp_parser (
	input wire logic     clk,
	input wire logic     arst_n,
	rtp_char_if.sink     chars,
	rtp_stamp_if.source  stamp
);

	logic                 valid_s1;
	logic [7:0]           char_s1;
	logic                 last_s1;
	logic                 advance;
	logic                 out_valid_q;
	rtp_pkg::stamp_t      res_q;
	rtp_pkg::scan_state_t nx;
	rtp_pkg::stamp_t      res;

	// Only a last character can wait, and only on a full result register
	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || stamp.ready);
	assign chars.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
			last_s1 <= chars.is_last;
		end
	end

	rtp_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance),
		.ch     (char_s1),
		.last   (last_s1),
		.nx     (nx)
	);

	rtp_check u_check (
		.st  (nx),
		.res (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (stamp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= res;
		end
	end

	assign stamp.valid               = out_valid_q;
	assign stamp.parse_ok            = res_q.parse_ok;
	assign stamp.year_value          = res_q.year_value;
	assign stamp.month_value         = res_q.month_value;
	assign stamp.day_value           = res_q.day_value;
	assign stamp.hour_value          = res_q.hour_value;
	assign stamp.minute_value        = res_q.minute_value;
	assign stamp.second_value        = res_q.second_value;
	assign stamp.micro_seconds       = res_q.micro_seconds;
	assign stamp.zone_offset_minutes = res_q.zone_offset_minutes;

	// A held input item is always a last character blocked by a pending result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (last_s1 && out_valid_q && !stamp.ready))
		else $error("input register held without an output stall");

	// A last character always leaves a result behind
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && last_s1) |=> out_valid_q)
		else $error("last character produced no result");

	// A bad string reports year, month, day, microseconds and zone offset as zero
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(stamp.valid && !stamp.parse_ok) |-> (stamp.year_value == 14'd0
		&& stamp.month_value == 4'd0 && stamp.day_value == 5'd0
		&& stamp.micro_seconds == 20'd0 && stamp.zone_offset_minutes == 12'sd0))
		else $error("fields not cleared on a bad string");

	// A good string carries month 1..12, day from 1, hour to 23, micro_seconds to 999999
	a_good_range: assert property (@(posedge clk) disable iff (!arst_n)
		(stamp.valid && stamp.parse_ok) |-> (stamp.month_value >= 4'd1
		&& stamp.month_value <= 4'd12 && stamp.day_value >= 5'd1
		&& stamp.hour_value <= 5'd23 && stamp.micro_seconds <= 20'd999999))
		else $error("accepted timestamp out of range");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import rtp_pkg::*;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 12;
	localparam int ITEM_TARGET    = 1050;
	localparam int STRING_TARGET  = 48;
	localparam int HOLD_AFTER     = 300;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 10;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int PRINT_LIMIT    = 200;
	localparam int unsigned MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	// Expected timestamps, worked out one character at a time
	class timestamp_scoreboard;
		stamp_t      pending_stamps[$];
		int unsigned mismatch_count;
		int unsigned checked_count;

		phase_t      phase;
		bit [5:0]    pos;
		bit          bad;
		bit [13:0]   year;
		bit [6:0]    month, day, hour, minute, second;
		bit [19:0]   frac;
		bit [2:0]    frac_cnt;
		bit          zone_neg;
		bit [6:0]    zone_hour, zone_minute;

		function new();
			mismatch_count = 0;
			checked_count = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			phase = PH_FIXED;
			pos = '0;
			bad = 1'b0;
			year = '0;
			month = '0;
			day = '0;
			hour = '0;
			minute = '0;
			second = '0;
			frac = '0;
			frac_cnt = '0;
			zone_neg = 1'b0;
			zone_hour = '0;
			zone_minute = '0;
		endfunction

		function bit is_num(bit [7:0] c);
			return c >= CH_ZERO && c <= CH_NINE;
		endfunction

		// Step through "YYYY-MM-DDTHH:MM:SS"; a bad digit holds the position
		function void scan_fixed(bit [7:0] c);
			bit [3:0] dv;
			dv = 4'(c - CH_ZERO);
			if (pos >= FIXED_LEN) begin
				bad = 1'b1;
				return;
			end
			case (pos)
				6'd4, 6'd7: begin
					if (c != CH_DASH) bad = 1'b1;
				end
				6'd10: begin
					if (c != CH_T_UP && c != CH_T_LO) bad = 1'b1;
				end
				6'd13, 6'd16: begin
					if (c != CH_COLON) bad = 1'b1;
				end
				default: begin
					if (!is_num(c)) begin
						bad = 1'b1;
						return;
					end
					if (pos < 4) year = year * 10 + dv;
					else if (pos < 7) month = month * 10 + dv;
					else if (pos < 10) day = day * 10 + dv;
					else if (pos < 13) hour = hour * 10 + dv;
					else if (pos < 16) minute = minute * 10 + dv;
					else second = second * 10 + dv;
				end
			endcase
			pos++;
			if (pos == FIXED_LEN) phase = PH_SECS;
		endfunction

		function void scan_zone_start(bit [7:0] c);
			if (c == CH_Z_UP || c == CH_Z_LO) begin
				phase = PH_ZULU;
			end else if (c == CH_PLUS || c == CH_DASH) begin
				zone_neg = (c == CH_DASH);
				phase = PH_OFFSET;
				pos = '0;
			end else begin
				bad = 1'b1;
			end
		endfunction

		function void scan_char(bit [7:0] c);
			bit [3:0] dv;
			dv = 4'(c - CH_ZERO);
			case (phase)
				PH_FIXED: scan_fixed(c);
				PH_SECS: begin
					if (c == CH_DOT) begin
						phase = PH_FRAC;
						frac_cnt = '0;
					end else begin
						scan_zone_start(c);
					end
				end
				PH_FRAC: begin
					if (is_num(c)) begin
						if (frac_cnt >= FRAC_DIGITS) begin
							bad = 1'b1;
						end else begin
							if (frac_cnt < MICRO_DIGITS) frac = frac * 10 + dv;
							frac_cnt++;
						end
					end else if (frac_cnt == 0) begin
						bad = 1'b1;
					end else begin
						scan_zone_start(c);
					end
				end
				PH_OFFSET: begin
					if (pos == 2) begin
						if (c != CH_COLON) bad = 1'b1;
					end else if (pos < ZONE_LEN && is_num(c)) begin
						if (pos < 2) zone_hour = zone_hour * 10 + dv;
						else zone_minute = zone_minute * 10 + dv;
					end else begin
						bad = 1'b1;
					end
					if (pos < ZONE_LEN) pos++;
				end
				default: bad = 1'b1;
			endcase
		endfunction

		// Validate the collected fields and build the expected result
		function stamp_t finish_stamp();
			stamp_t s;
			bit ok, leap;
			int unsigned lim, micro, off;
			s = '0;
			ok = !bad && phase != PH_FIXED;
			if (phase == PH_FRAC && frac_cnt == 0) ok = 1'b0;
			if (phase == PH_OFFSET && pos != ZONE_LEN) ok = 1'b0;
			if (year < 1 || year > 9999) ok = 1'b0;
			if (month < 1 || month > 12) ok = 1'b0;
			if (day < 1 || day > 31) ok = 1'b0;
			if (ok) begin
				lim = MONTH_LEN[month - 1];
				leap = (year % 4 == 0 && year % 100 != 0) || year % 400 == 0;
				if (month == 2 && leap) lim++;
				if (day > lim) ok = 1'b0;
			end
			if (hour > 23 || minute > 59 || second > 59) ok = 1'b0;
			if (phase == PH_OFFSET && (zone_hour > 23 || zone_minute > 59)) ok = 1'b0;
			if (!ok) return s;
			micro = frac;
			if (phase != PH_SECS) begin
				for (int k = frac_cnt; k < MICRO_DIGITS; k++) micro = micro * 10;
			end
			off = (phase == PH_OFFSET) ? zone_hour * 60 + zone_minute : 0;
			s.parse_ok = 1'b1;
			s.year_value = year;
			s.month_value = 4'(month);
			s.day_value = 5'(day);
			s.hour_value = 5'(hour);
			s.minute_value = 6'(minute);
			s.second_value = 6'(second);
			s.micro_seconds = 20'(micro);
			s.zone_offset_minutes = zone_neg ? 12'(0 - off) : 12'(off);
			return s;
		endfunction

		function void note_char(bit [7:0] c, bit last);
			if (c != CH_SPACE) scan_char(c);
			if (last) begin
				pending_stamps.push_back(finish_stamp());
				clear_scan();
			end
		endfunction

		task report(string msg);
			if (mismatch_count < PRINT_LIMIT) $display("[%0t] mismatch: %s", $realtime, msg);
			mismatch_count++;
		endtask

		task check_stamp(stamp_t got);
			stamp_t want;
			if (pending_stamps.size() == 0) begin
				report("result item with no string outstanding");
				return;
			end
			want = pending_stamps.pop_front();
			if (got.parse_ok !== want.parse_ok)
				report($sformatf("stamp %0d parse_ok got %0d want %0d",
					checked_count, got.parse_ok, want.parse_ok));
			if (got.year_value !== want.year_value)
				report($sformatf("stamp %0d year_value got %0d want %0d",
					checked_count, got.year_value, want.year_value));
			if (got.month_value !== want.month_value)
				report($sformatf("stamp %0d month_value got %0d want %0d",
					checked_count, got.month_value, want.month_value));
			if (got.day_value !== want.day_value)
				report($sformatf("stamp %0d day_value got %0d want %0d",
					checked_count, got.day_value, want.day_value));
			if (got.hour_value !== want.hour_value)
				report($sformatf("stamp %0d hour_value got %0d want %0d",
					checked_count, got.hour_value, want.hour_value));
			if (got.minute_value !== want.minute_value)
				report($sformatf("stamp %0d minute_value got %0d want %0d",
					checked_count, got.minute_value, want.minute_value));
			if (got.second_value !== want.second_value)
				report($sformatf("stamp %0d second_value got %0d want %0d",
					checked_count, got.second_value, want.second_value));
			if (got.micro_seconds !== want.micro_seconds)
				report($sformatf("stamp %0d micro_seconds got %0d want %0d",
					checked_count, got.micro_seconds, want.micro_seconds));
			if (got.zone_offset_minutes !== want.zone_offset_minutes)
				report($sformatf("stamp %0d zone_offset_minutes got %0d want %0d",
					checked_count, got.zone_offset_minutes, want.zone_offset_minutes));
			checked_count++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	rtp_char_if  chars();
	rtp_stamp_if stamp();

	rfc3339_timestamp_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.stamp  (stamp)
	);

	timestamp_scoreboard sb = new();

	bit [7:0]    text[$];
	stamp_t      seen;
	int unsigned chars_sent;
	int unsigned strings_sent;
	int unsigned chars_taken;
	int unsigned burst_left;
	int unsigned cycle_count;

	always #CLK_HALF clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Note accepted characters and check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (chars.valid && chars.ready) begin
				sb.note_char(chars.char_code, chars.is_last);
				chars_taken++;
			end
			if (stamp.valid && stamp.ready) begin
				seen.parse_ok = stamp.parse_ok;
				seen.year_value = stamp.year_value;
				seen.month_value = stamp.month_value;
				seen.day_value = stamp.day_value;
				seen.hour_value = stamp.hour_value;
				seen.minute_value = stamp.minute_value;
				seen.second_value = stamp.second_value;
				seen.micro_seconds = stamp.micro_seconds;
				seen.zone_offset_minutes = stamp.zone_offset_minutes;
				sb.check_stamp(seen);
			end
		end
	end

	// Stall the result side on its own pattern, with one long hold-off
	initial begin
		bit          held_once;
		int unsigned pattern_left;
		int unsigned pct;
		held_once = 1'b0;
		pattern_left = 0;
		pct = 100;
		stamp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held_once && chars_taken >= HOLD_AFTER) begin
				held_once = 1'b1;
				stamp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (pattern_left == 0) begin
				case ($urandom_range(0, 4))
					0, 1: pct = 100;
					2: pct = 75;
					3: pct = 40;
					default: pct = 10;
				endcase
				pattern_left = $urandom_range(10, 80);
			end
			pattern_left--;
			stamp.ready <= ($urandom_range(1, 100) <= pct);
		end
	end

	function automatic void push_num(ref bit [7:0] s[$], input int unsigned v,
			input int n);
		int base;
		base = s.size();
		for (int k = 0; k < n; k++) begin
			s.insert(base, 8'(CH_ZERO + v % 10));
			v = v / 10;
		end
	endfunction

	function automatic int unsigned pick_field(int unsigned lo, int unsigned hi);
		case ($urandom_range(0, 15))
			0: return 0;
			1: return lo;
			2: return hi;
			3: return hi + 1;
			4: return 99;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	function automatic bit [7:0] any_digit();
		return 8'(CH_ZERO + $urandom_range(0, 9));
	endfunction

	// Timestamp layout with random field values, extremes favoured; some parts malformed
	function automatic void build_stamp_text(ref bit [7:0] s[$]);
		int unsigned yr, mo, dy, n, style;
		yr = pick_field(1, 9999);
		mo = pick_field(1, 12);
		if (mo == 2 && $urandom_range(0, 2) == 0) begin
			dy = $urandom_range(28, 30);
			case ($urandom_range(0, 5))
				0: yr = 2000;
				1: yr = 1900;
				2: yr = 2400;
				3: yr = 2100;
				4: yr = 4 * $urandom_range(1, 2499);
				default: ;
			endcase
		end else begin
			dy = pick_field(1, 31);
		end
		push_num(s, yr, 4);
		s.push_back(CH_DASH);
		push_num(s, mo, 2);
		s.push_back(CH_DASH);
		push_num(s, dy, 2);
		s.push_back($urandom_range(0, 1) ? CH_T_UP : CH_T_LO);
		push_num(s, pick_field(0, 23), 2);
		s.push_back(CH_COLON);
		push_num(s, pick_field(0, 59), 2);
		s.push_back(CH_COLON);
		push_num(s, pick_field(0, 59), 2);

		// fraction: none, bare dot, one digit too many, or 1..6 digits
		case ($urandom_range(0, 9))
			0, 1, 2: ;
			3: s.push_back(CH_DOT);
			4: begin
				s.push_back(CH_DOT);
				repeat (FRAC_DIGITS + 1) s.push_back(any_digit());
			end
			default: begin
				s.push_back(CH_DOT);
				n = $urandom_range(1, FRAC_DIGITS);
				style = $urandom_range(0, 2);
				repeat (n) s.push_back(style == 0 ? any_digit() : (style == 1 ? CH_NINE : CH_ZERO));
			end
		endcase

		// zone: none, Z, z, negative zero, or a signed offset
		case ($urandom_range(0, 9))
			0, 1: ;
			2: s.push_back(CH_Z_UP);
			3: s.push_back(CH_Z_LO);
			4: begin
				s.push_back(CH_DASH);
				push_num(s, 0, 2);
				s.push_back(CH_COLON);
				push_num(s, 0, 2);
			end
			default: begin
				s.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
				push_num(s, pick_field(0, 23), 2);
				s.push_back(CH_COLON);
				push_num(s, pick_field(0, 59), 2);
			end
		endcase
		if ($urandom_range(0, 11) == 0) s.push_back($urandom_range(0, 1) ? CH_Z_UP : any_digit());
	endfunction

	// Mostly well-formed strings, some cut short, mangled or pure noise
	function automatic void make_string(ref bit [7:0] s[$]);
		int unsigned kind, idx, len;
		s.delete();
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			build_stamp_text(s);
			if (kind >= 70) begin
				len = $urandom_range(1, s.size() - 1);
				while (s.size() > len) void'(s.pop_back());
			end else if ($urandom_range(0, 6) == 0) begin
				idx = $urandom_range(0, s.size() - 1);
				case ($urandom_range(0, 2))
					0: s[idx] = 8'($urandom_range(0, 255));
					1: s.delete(idx);
					default: s.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end else begin
			len = $urandom_range(1, 24);
			repeat (len) s.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : any_digit());
		end
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 3)) s.insert($urandom_range(0, s.size()), CH_SPACE);
		end
		if ($urandom_range(0, 9) == 0) s.push_back(CH_SPACE);
	endfunction

	// Offer one character; idle between bursts of random length
	task automatic send_char(input bit [7:0] code, input bit last);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				chars.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
				: $urandom_range(1, 12);
		end
		burst_left--;
		chars.valid <= 1'b1;
		chars.char_code <= code;
		chars.is_last <= last;
		@(posedge clk);
		while (!chars.ready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text();
		foreach (text[i]) send_char(text[i], i == text.size() - 1);
		strings_sent++;
	endtask

	function automatic void load_text(string t);
		text.delete();
		foreach (t[i]) text.push_back(t[i]);
	endfunction

	initial begin
		arst_n = 1'b0;
		chars.valid <= 1'b0;
		chars.char_code <= '0;
		chars.is_last <= 1'b0;
		burst_left = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: lone space on the last item, NUL, non-ASCII, bare Z,
		// and the smallest valid timestamp
		text.delete();
		text.push_back(CH_SPACE);
		send_text();
		text.delete();
		text.push_back(8'h00);
		send_text();
		text.delete();
		text.push_back(8'hFF);
		send_text();
		load_text("Z");
		send_text();
		load_text("0001-01-01T00:00:00");
		send_text();

		// Random strings until enough characters and strings have been sent
		while (chars_sent < ITEM_TARGET || strings_sent < STRING_TARGET) begin
			make_string(text);
			send_text();
		end
		chars.valid <= 1'b0;

		// Drain outstanding results, then allow for any late stray item
		@(posedge clk);
		while (sb.pending_stamps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
